FILE: rtl/dmx_scene_crossfader_defines.svh
// Assertion macros used by the checker file
`ifndef DMX_SCENE_CROSSFADER_DEFINES_SVH
`define DMX_SCENE_CROSSFADER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while in reset
`define DXF_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dmx crossfader check failed");

// Next-cycle implication, sampled on clk, off while in reset
`define DXF_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dmx crossfader check failed");

`endif

FILE: rtl/dmx_xf_pkg.sv
package dmx_xf_pkg;

	// Default sizes
	localparam int SCENES_DEF  = 16;
	localparam int OUTPUTS_DEF = 4;
	localparam int SLOTS_DEF   = 512;

	// Command codes
	localparam logic [2:0] CMD_WR_SCENE = 3'd0;
	localparam logic [2:0] CMD_WR_LIVE  = 3'd1;
	localparam logic [2:0] CMD_RECALL   = 3'd2;
	localparam logic [2:0] CMD_HOME     = 3'd3;
	localparam logic [2:0] CMD_TICK     = 3'd4;
	localparam logic [2:0] CMD_RD_LIVE  = 3'd5;

	// Configuration register indexes
	localparam logic [1:0] REG_MASK = 2'd0;
	localparam logic [1:0] REG_HOME = 2'd1;

	typedef enum logic [4:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DECODE,
		ST_READ_WAIT,
		ST_RC_NEXT,
		ST_RC_RD,
		ST_RC_WR,
		ST_TK_NEXT,
		ST_CP_RD,
		ST_CP_WR,
		ST_BL_RD,
		ST_BL_MUL,
		ST_BL_DIV,
		ST_BL_WR,
		ST_FINISH
	} state_t;

endpackage

FILE: rtl/dmx_scene_crossfader.sv
// Recall steps through every slot of each output touched; tick steps through every slot
// of each output that completes (copy) and of each output still fading (blend, with
// one shared 8-step divider per slot).
// One item at a time; start is taken only while busy is low, done strobes one cycle.
// Reset is asynchronous; afterwards a clearing pass zeroes the scene store and live frames
// while busy stays high.
module dmx_scene_crossfader
	import dmx_xf_pkg::*;
#(
	parameter int SCENES  = SCENES_DEF,
	parameter int OUTPUTS = OUTPUTS_DEF,
	parameter int SLOTS   = SLOTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  command,
	input  logic [3:0]  scene_index,
	input  logic [1:0]  output_index,
	input  logic        all_outputs,
	input  logic [8:0]  channel,
	input  logic [7:0]  value,
	input  logic [15:0] fade_ms,
	output logic        done,
	output logic [7:0]  read_value,
	output logic        accepted,
	output logic        fading,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [3:0]  cfg_data
);

	localparam int FRAME_CELLS = OUTPUTS * SLOTS;
	localparam int SCENE_CELLS = SCENES * FRAME_CELLS;
	localparam int SC_AW = (SCENE_CELLS > 1) ? $clog2(SCENE_CELLS) : 1;
	localparam int FR_AW = (FRAME_CELLS > 1) ? $clog2(FRAME_CELLS) : 1;
	localparam int OUT_W = (OUTPUTS > 1) ? $clog2(OUTPUTS) : 1;
	localparam int OC_W  = $clog2(OUTPUTS + 1);
	localparam int CH_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	state_t state_q, state_d;

	// Latched item
	logic [2:0]  cmd_q;
	logic [3:0]  scn_q;
	logic [1:0]  o_q;
	logic        all_q;
	logic [8:0]  ch_q;
	logic [7:0]  val_q;
	logic [15:0] len_q;
	logic        acc_q;
	logic [7:0]  rd_q;

	// Config
	logic [3:0] mask_q;
	logic [3:0] home_q;

	// Fade state
	logic        active_q  [OUTPUTS];
	logic [15:0] elapsed_q [OUTPUTS];
	logic [15:0] length_q  [OUTPUTS];

	// Sequencer counters and divider
	logic [SC_AW-1:0] clr_q;
	logic [OC_W-1:0]  ok_q;
	logic [CH_W-1:0]  c_q;
	logic             loop_all_q;
	logic             neg_q;
	logic [7:0]       a_q;
	logic [23:0]      rem_q;
	logic [7:0]       quo_q;
	logic [2:0]       step_q;

	// Result registers
	logic       done_q;
	logic [7:0] read_value_q;
	logic       accepted_q;
	logic       fading_q;

	// RAM ports
	logic             sc_we;
	logic [SC_AW-1:0] sc_waddr, sc_raddr;
	logic [7:0]       sc_wdata, sc_rdata;
	logic             lv_we;
	logic [FR_AW-1:0] lv_waddr, lv_raddr;
	logic [7:0]       lv_wdata, lv_rdata;
	logic             st_we;
	logic [FR_AW-1:0] st_raddr;
	logic [7:0]       st_rdata;
	logic             tg_we;
	logic [FR_AW-1:0] tg_raddr;
	logic [7:0]       tg_rdata;

	// Derived control
	logic [OUT_W-1:0] oi;
	logic [OUT_W-1:0] oq_idx;
	logic [3:0]       scn_sel;
	logic             oin, cin, sin;
	logic             last_slot, loop_end, en_cur, clr_last;
	logic [3:0]       mask_sh;
	logic [15:0]      e_next;
	logic [FR_AW-1:0] fr_cur, fr_item;
	logic [SC_AW-1:0] sc_cur, sc_item;
	logic [23:0]      div_sub;
	logic             div_ge;
	logic [7:0]       bl_d;
	logic [23:0]      bl_prod;

	assign oi       = ok_q[OUT_W-1:0];
	assign oq_idx   = OUT_W'(o_q);
	assign scn_sel  = (cmd_q == CMD_HOME) ? home_q : scn_q;
	assign oin      = int'(o_q) < OUTPUTS;
	assign cin      = int'(ch_q) < SLOTS;
	assign sin      = int'(scn_sel) < SCENES;
	assign last_slot = int'(c_q) == SLOTS - 1;
	assign loop_end = int'(ok_q) == OUTPUTS;
	assign clr_last = int'(clr_q) == SCENE_CELLS - 1;
	assign mask_sh  = mask_q >> ok_q;
	assign en_cur   = mask_sh[0];
	assign e_next   = (elapsed_q[oi] == 16'hFFFF) ? 16'hFFFF : elapsed_q[oi] + 16'd1;
	assign fr_cur   = FR_AW'(int'(oi) * SLOTS + int'(c_q));
	assign fr_item  = FR_AW'(int'(o_q) * SLOTS + int'(ch_q));
	assign sc_cur   = SC_AW'((int'(scn_q) * OUTPUTS + int'(oi)) * SLOTS + int'(c_q));
	assign sc_item  = SC_AW'((int'(scn_q) * OUTPUTS + int'(o_q)) * SLOTS + int'(ch_q));
	assign div_sub  = {8'd0, length_q[oi]} << step_q;
	assign div_ge   = rem_q >= div_sub;
	assign bl_d     = (tg_rdata < st_rdata) ? st_rdata - tg_rdata : tg_rdata - st_rdata;
	assign bl_prod  = {16'd0, bl_d} * {8'd0, elapsed_q[oi]};

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR:     if (clr_last) state_d = ST_IDLE;
			ST_IDLE:      if (start) state_d = ST_DECODE;
			ST_DECODE: begin
				unique case (cmd_q) inside
					CMD_RD_LIVE: state_d = (oin && cin) ? ST_READ_WAIT : ST_FINISH;
					CMD_RECALL, CMD_HOME: begin
						if (!sin) state_d = ST_FINISH;
						else if (all_q) state_d = ST_RC_NEXT;
						else if (!oin) state_d = ST_FINISH;
						else state_d = ST_RC_RD;
					end
					CMD_TICK:    state_d = ST_TK_NEXT;
					default:     state_d = ST_FINISH;
				endcase
			end
			ST_READ_WAIT: state_d = ST_FINISH;
			ST_RC_NEXT: begin
				if (loop_end) state_d = ST_FINISH;
				else if (en_cur) state_d = ST_RC_RD;
			end
			ST_RC_RD:     state_d = ST_RC_WR;
			ST_RC_WR: begin
				if (!last_slot) state_d = ST_RC_RD;
				else state_d = loop_all_q ? ST_RC_NEXT : ST_FINISH;
			end
			ST_TK_NEXT: begin
				if (loop_end) state_d = ST_FINISH;
				else if (active_q[oi]) state_d = (e_next >= length_q[oi]) ? ST_CP_RD : ST_BL_RD;
			end
			ST_CP_RD:     state_d = ST_CP_WR;
			ST_CP_WR:     state_d = last_slot ? ST_TK_NEXT : ST_CP_RD;
			ST_BL_RD:     state_d = ST_BL_MUL;
			ST_BL_MUL:    state_d = ST_BL_DIV;
			ST_BL_DIV:    if (step_q == 3'd0) state_d = ST_BL_WR;
			ST_BL_WR:     state_d = last_slot ? ST_TK_NEXT : ST_BL_RD;
			ST_FINISH:    state_d = ST_IDLE;
			default:      state_d = ST_IDLE;
		endcase
	end

	// Memory controls
	always_comb begin
		sc_we    = 1'b0;
		sc_waddr = sc_item;
		sc_wdata = val_q;
		sc_raddr = sc_cur;
		lv_we    = 1'b0;
		lv_waddr = fr_cur;
		lv_wdata = tg_rdata;
		lv_raddr = fr_item;
		st_we    = 1'b0;
		tg_we    = 1'b0;
		st_raddr = fr_cur;
		tg_raddr = fr_cur;
		unique case (state_q)
			ST_CLEAR: begin
				sc_we    = 1'b1;
				sc_waddr = clr_q;
				sc_wdata = 8'd0;
				lv_we    = int'(clr_q) < FRAME_CELLS;
				lv_waddr = FR_AW'(clr_q);
				lv_wdata = 8'd0;
			end
			ST_DECODE: begin
				sc_we    = (cmd_q == CMD_WR_SCENE) && sin && oin && cin;
				lv_we    = (cmd_q == CMD_WR_LIVE) && oin && cin;
				lv_waddr = fr_item;
				lv_wdata = val_q;
			end
			ST_RC_RD:  lv_raddr = fr_cur;
			ST_RC_WR: begin
				st_we = 1'b1;
				tg_we = 1'b1;
			end
			ST_CP_WR:  lv_we = 1'b1;
			ST_BL_WR: begin
				lv_we    = 1'b1;
				lv_wdata = neg_q ? a_q - quo_q : a_q + quo_q;
			end
			default: ;
		endcase
	end

	// Sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_q      <= '0;
			ok_q       <= '0;
			c_q        <= '0;
			loop_all_q <= 1'b0;
			acc_q      <= 1'b1;
			rd_q       <= 8'd0;
			step_q     <= 3'd0;
			done_q     <= 1'b0;
			for (int i = 0; i < OUTPUTS; i++) begin
				active_q[i]  <= 1'b0;
				elapsed_q[i] <= 16'd0;
				length_q[i]  <= 16'd0;
			end
		end else begin
			state_q <= state_d;
			done_q  <= state_q == ST_FINISH;
			unique case (state_q)
				ST_CLEAR: clr_q <= clr_q + 1'b1;
				ST_IDLE: begin
					acc_q <= 1'b1;
					rd_q  <= 8'd0;
				end
				ST_DECODE: begin
					c_q        <= '0;
					loop_all_q <= all_q;
					unique case (cmd_q) inside
						CMD_WR_SCENE: acc_q <= sin && oin && cin;
						CMD_WR_LIVE,
						CMD_RD_LIVE:  acc_q <= oin && cin;
						CMD_RECALL, CMD_HOME: begin
							acc_q <= sin && (all_q || oin);
							ok_q  <= all_q ? '0 : OC_W'(o_q);
						end
						CMD_TICK:     ok_q <= '0;
						default:      acc_q <= 1'b1;
					endcase
				end
				ST_READ_WAIT: rd_q <= lv_rdata;
				ST_RC_NEXT: begin
					c_q <= '0;
					if (!loop_end && !en_cur) ok_q <= ok_q + 1'b1;
				end
				ST_RC_WR: begin
					c_q <= c_q + 1'b1;
					if (last_slot) begin
						active_q[oi]  <= 1'b1;
						elapsed_q[oi] <= 16'd0;
						length_q[oi]  <= len_q;
						ok_q          <= ok_q + 1'b1;
						c_q           <= '0;
					end
				end
				ST_TK_NEXT: begin
					c_q <= '0;
					if (!loop_end) begin
						if (active_q[oi]) elapsed_q[oi] <= e_next;
						else ok_q <= ok_q + 1'b1;
					end
				end
				ST_CP_WR: begin
					c_q <= c_q + 1'b1;
					if (last_slot) begin
						active_q[oi] <= 1'b0;
						ok_q         <= ok_q + 1'b1;
						c_q          <= '0;
					end
				end
				ST_BL_MUL: step_q <= 3'd7;
				ST_BL_DIV: step_q <= step_q - 3'd1;
				ST_BL_WR: begin
					c_q <= c_q + 1'b1;
					if (last_slot) begin
						ok_q <= ok_q + 1'b1;
						c_q  <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	// Item latch, divider datapath, result payload
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			cmd_q <= command;
			scn_q <= scene_index;
			o_q   <= output_index;
			all_q <= all_outputs;
			ch_q  <= channel;
			val_q <= value;
			len_q <= fade_ms;
		end
		if (state_q == ST_DECODE) begin
			scn_q <= scn_sel;
			if (cmd_q == CMD_HOME) len_q <= 16'd0;
		end
		if (state_q == ST_BL_MUL) begin
			a_q   <= st_rdata;
			neg_q <= tg_rdata < st_rdata;
			rem_q <= (tg_rdata < st_rdata) ? bl_prod + 24'(length_q[oi]) - 24'd1 : bl_prod;
			quo_q <= 8'd0;
		end
		if (state_q == ST_BL_DIV && div_ge) begin
			rem_q        <= rem_q - div_sub;
			quo_q[step_q] <= 1'b1;
		end
		if (state_q == ST_FINISH) begin
			read_value_q <= rd_q;
			accepted_q   <= acc_q;
			fading_q     <= oin && active_q[oq_idx];
		end
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= 4'd15;
			home_q <= 4'd0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_MASK: mask_q <= cfg_data;
				REG_HOME: home_q <= cfg_data;
				default: ;
			endcase
		end
	end

	dmx_xf_ram #(.WIDTH(8), .DEPTH(SCENE_CELLS)) u_scene (
		.clk(clk), .we(sc_we), .waddr(sc_waddr), .wdata(sc_wdata),
		.raddr(sc_raddr), .rdata(sc_rdata)
	);

	dmx_xf_ram #(.WIDTH(8), .DEPTH(FRAME_CELLS)) u_live (
		.clk(clk), .we(lv_we), .waddr(lv_waddr), .wdata(lv_wdata),
		.raddr(lv_raddr), .rdata(lv_rdata)
	);

	dmx_xf_ram #(.WIDTH(8), .DEPTH(FRAME_CELLS)) u_start (
		.clk(clk), .we(st_we), .waddr(fr_cur), .wdata(lv_rdata),
		.raddr(st_raddr), .rdata(st_rdata)
	);

	dmx_xf_ram #(.WIDTH(8), .DEPTH(FRAME_CELLS)) u_target (
		.clk(clk), .we(tg_we), .waddr(fr_cur), .wdata(sc_rdata),
		.raddr(tg_raddr), .rdata(tg_rdata)
	);

	assign busy       = state_q != ST_IDLE;
	assign cfg_ready  = 1'b1;
	assign done       = done_q;
	assign read_value = read_value_q;
	assign accepted   = accepted_q;
	assign fading     = fading_q;

endmodule

FILE: rtl/dmx_xf_ram.sv
module dmx_xf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 512,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/dmx_xf_checker.sv
`include "dmx_scene_crossfader_defines.svh"

module dmx_xf_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       done,
	input logic [7:0] read_value,
	input logic       accepted
);

	// Accepted command holds the block busy
	`DXF_ASSERT_NEXT(a_start_busy, start && !busy, busy)
	// Result strobe lasts one cycle
	`DXF_ASSERT_NEXT(a_done_pulse, done, !done)
	// Result shows only once the block is free again
	`DXF_ASSERT_NOW(a_done_idle, done, !busy)
	// Rejected command reads back zero
	`DXF_ASSERT_NOW(a_reject_zero, done && !accepted, read_value == 8'd0)

endmodule

bind dmx_scene_crossfader dmx_xf_checker u_dmx_xf_checker (.*);
